FILE: sv/fpdl_pkg.sv
package fpdl_pkg;

   localparam int DATA_W     = 16;
   localparam int ACC_W      = 32;
   localparam int IDX_W      = 9;
   localparam int LEN_W      = 10;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int Q_SHIFT    = 12;

   localparam int MAX_INPUTS_DEFAULT = 512;

   localparam logic [LEN_W-1:0] INPUT_LENGTH_RESET  = LEN_W'(512);
   localparam logic [LEN_W-1:0] OUTPUT_LENGTH_RESET = LEN_W'(512);

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ENABLE   = 2'd2;

endpackage

FILE: sv/fixed_point_dense_layer.sv
// A bias request passes the stage 1, stage 2 and output registers in turn.
// Throughput: one request per cycle unless a held result stalls; set by the
// single activation memory read and one multiply-accumulate into the sum.
// Reset (synchronous, active high) clears the pipeline, accumulator and output
// counter and resets the registers; the activation memory is not cleared.
module fixed_point_dense_layer #(
   parameter int MAX_INPUTS = fpdl_pkg::MAX_INPUTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fpdl_pkg::KIND_W-1:0]          req_kind,
   input  logic [fpdl_pkg::IDX_W-1:0]           req_index,
   input  logic signed [fpdl_pkg::DATA_W-1:0]   req_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fpdl_pkg::DATA_W-1:0]   rsp_output_value,
   output logic [fpdl_pkg::IDX_W-1:0]           rsp_output_index,
   output logic                                 rsp_saturated,
   output logic                                 rsp_last_output,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fpdl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fpdl_pkg::LEN_W-1:0]           csr_data
);

   localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int DW = fpdl_pkg::DATA_W;
   localparam int CW = fpdl_pkg::ACC_W;
   localparam int QS = fpdl_pkg::Q_SHIFT;
   localparam int IW = fpdl_pkg::IDX_W;
   localparam int LW = fpdl_pkg::LEN_W;

   // configuration
   logic [LW-1:0] input_length_ff;
   logic [LW-1:0] output_length_ff;
   logic          relu_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_length_ff  <= fpdl_pkg::INPUT_LENGTH_RESET;
         output_length_ff <= fpdl_pkg::OUTPUT_LENGTH_RESET;
         relu_enable_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fpdl_pkg::CSR_INPUT_LENGTH:  input_length_ff  <= csr_data;
            fpdl_pkg::CSR_OUTPUT_LENGTH: output_length_ff <= csr_data;
            fpdl_pkg::CSR_RELU_ENABLE:   relu_enable_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_value_ff;
   logic [IW-1:0]        rsp_index_ff;
   logic                 rsp_sat_ff;
   logic                 rsp_last_ff;

   // whole pipeline moves unless a finished result is held by the consumer
   logic adv;
   logic accept;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   logic          in_range;
   logic [AW-1:0] addr;
   assign in_range = (32'(req_index) < MAX_INPUTS);
   assign addr     = AW'(req_index);

   // activation memory
   logic signed [DW-1:0] act_mem [MAX_INPUTS];
   logic signed [DW-1:0] act_rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_kind == fpdl_pkg::KIND_LOAD && in_range) begin
            act_mem[addr] <= req_value;
         end
         act_rd_ff <= act_mem[addr];
      end
   end

   // stage 1: request register
   logic                 s1_mac_ff, s1_mac_in;
   logic                 s1_bias_ff, s1_bias_in;
   logic signed [DW-1:0] s1_value_ff;

   assign s1_mac_in  = accept && req_kind == fpdl_pkg::KIND_WEIGHT && in_range
                       && ({1'b0, req_index} < input_length_ff);
   assign s1_bias_in = accept && req_kind == fpdl_pkg::KIND_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mac_ff  <= 1'b0;
         s1_bias_ff <= 1'b0;
      end else if (adv) begin
         s1_mac_ff  <= s1_mac_in;
         s1_bias_ff <= s1_bias_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff <= req_value;
      end
   end

   // stage 2: product register
   logic                 s2_mac_ff;
   logic                 s2_bias_ff;
   logic signed [DW-1:0] s2_value_ff;
   logic signed [CW-1:0] s2_prod_ff, s2_prod_in;

   assign s2_prod_in = CW'($signed(act_rd_ff) * $signed(s1_value_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mac_ff  <= 1'b0;
         s2_bias_ff <= 1'b0;
      end else if (adv) begin
         s2_mac_ff  <= s1_mac_ff;
         s2_bias_ff <= s1_bias_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_value_ff <= s1_value_ff;
         s2_prod_ff  <= s2_prod_in;
      end
   end

   // stage 3: accumulate, or finish the neuron into the output register
   logic [CW-1:0]        acc_ff, acc_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        bias_ext;
   logic [CW-1:0]        sum;
   logic [CW-QS-DW:0]    sum_hi;
   logic                 sat;
   logic signed [DW-1:0] clamped;
   logic signed [DW-1:0] result;
   logic                 last;

   always_comb begin
      bias_ext = CW'(s2_value_ff) << QS;
      sum      = acc_ff + bias_ext;
      // shifted sum fits in 16 bits when the bits above its sign all agree
      sum_hi   = sum[CW-1:QS+DW-1];
      sat      = !((&sum_hi) || !(|sum_hi));
      if (sat) begin
         clamped = sum[CW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         clamped = sum[QS+DW-1:QS];
      end
      result = (relu_enable_ff && sum[CW-1]) ? '0 : clamped;
      last   = (output_length_ff != '0) && ({1'b0, cnt_ff} == output_length_ff - 1'b1);

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (s2_mac_ff) begin
         acc_in = acc_ff + s2_prod_ff;
      end else if (s2_bias_ff) begin
         acc_in = '0;
         cnt_in = last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= s2_bias_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_bias_ff) begin
         rsp_value_ff <= result;
         rsp_index_ff <= cnt_ff;
         rsp_sat_ff   <= sat;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_value = rsp_value_ff;
   assign rsp_output_index = rsp_index_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last_output  = rsp_last_ff;

   // a new result only ever comes from a bias request in stage 2
   a_rsp_from_bias: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_bias_ff))
      else $error("result appeared without a bias request");

   // emitting a result clears the running sum
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_bias_ff) |=> (acc_ff == '0))
      else $error("accumulator not cleared after result");

   // counter already points at the output after the one being held
   a_cnt_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cnt_ff == (rsp_last_ff ? '0 : rsp_index_ff + 1'b1)))
      else $error("output counter out of step with held result");

endmodule
